[hdl/rgbac_pkg.sv]
// ============================================================================
// RGBA 3x3 convolution package
// Shared types and constants for the streaming 3x3 RGBA filter.
// ============================================================================
package rgbac_pkg;

    // Pixel layout: channel 0 is red, then green, blue, alpha.
    localparam int NUM_CH  = 4;
    localparam int CHAN_W  = 8;
    localparam int COEF_W  = 16;
    localparam int TAPS    = 3;

    // Product of an 8-bit pixel (as a 9-bit signed value) and a 16-bit
    // coefficient, sum of one window column, sum of the whole window.
    localparam int PROD_W  = CHAN_W + 1 + COEF_W;
    localparam int CSUM_W  = PROD_W + 2;
    localparam int TSUM_W  = CSUM_W + 2;

    localparam int POS_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int DIM_CFG_W  = 13;

    localparam logic [DIM_CFG_W-1:0]  FRAME_WIDTH_RST  = 13'd640;
    localparam logic [DIM_CFG_W-1:0]  FRAME_HEIGHT_RST = 13'd480;
    localparam logic [CFG_DATA_W-1:0] COEF_ROW_RST     = 48'h071C_071C_071C;
    localparam logic [CHAN_W-1:0]     CHAN_MAX         = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_COEF_TOP     = 3'd2,
        REG_COEF_MID     = 3'd3,
        REG_COEF_BOTTOM  = 3'd4
    } cfg_reg_t;

    typedef logic [CHAN_W-1:0]                chan_t;
    typedef chan_t [NUM_CH-1:0]               pixel_t;
    // One window column: index 0 is the top line, 2 the current line.
    typedef pixel_t [TAPS-1:0]                column_t;
    // The three coefficients a column cell uses, top row first.
    typedef logic [TAPS-1:0][COEF_W-1:0]      coef_col_t;
    typedef logic [NUM_CH-1:0][CSUM_W-1:0]    csum_vec_t;

    typedef struct packed {
        logic load;   // shift a new column into the window
        logic adv;    // the arithmetic pipeline moves forward
    } cell_ctl_t;

    typedef struct packed {
        logic              done;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } meta_t;

endpackage

[hdl/rgbac_ram.sv]
// ============================================================================
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ============================================================================
module rgbac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/rgbac_cell.sv]
// ============================================================================
// Window column cell
// Holds one column of the 3x3 window, passes it to its left neighbor and
// forms the weighted column sum for each channel.
// ============================================================================
module rgbac_cell
    import rgbac_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  column_t   col_in,
    input  coef_col_t coef,
    output column_t   col_out,
    output csum_vec_t sum_out
);

    column_t                                  col_reg;
    logic [TAPS-1:0][NUM_CH-1:0][PROD_W-1:0]  prod_reg;
    logic [TAPS-1:0][NUM_CH-1:0][PROD_W-1:0]  prod_next;
    csum_vec_t                                sum_reg;
    csum_vec_t                                sum_next;

    // Each product takes the pixel as a non-negative signed value. Both
    // operands are extended to the full product width first.
    always_comb
    begin
        for (int y = 0; y < TAPS; y++)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                prod_next[y][ch] = $signed(PROD_W'({1'b0, col_reg[y][ch]})) *
                                   $signed(PROD_W'($signed(coef[y])));
            end
        end
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            sum_next[ch] = CSUM_W'($signed(prod_reg[0][ch])) +
                           CSUM_W'($signed(prod_reg[1][ch])) +
                           CSUM_W'($signed(prod_reg[2][ch]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            col_reg <= col_in;
        end
        if (ctl.adv)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

    assign col_out = col_reg;
    assign sum_out = sum_reg;

endmodule

[hdl/rgba_convolution_3x3.sv]
// ============================================================================
// RGBA 3x3 convolution
// Streaming 3x3 filter over RGBA pixels in raster order, one kernel per image.
// ============================================================================
// The input channel takes one RGBA word per clock (in_valid, in_stall) in
// raster order unless stalled. Two line stores keep the previous two lines,
// and a chain of three column cells forms the 3x3 window. For each interior
// pixel one output word appears on the output channel (out_valid, out_stall)
// with the filtered channels, the position of the center pixel and frame_done
// on the last interior pixel. Border pixels give no output word.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and should only be written while no words are in flight.
// Throughput is one word per clock while out_stall does not hold the output.
// An accepted input word passes through the line store read, the window
// shift, the multipliers, the column sums and the final sum with truncation
// and saturation into the output register.
// The pipeline moves as one unit: while out_valid is high and out_stall is
// asserted, in_stall is raised and everything in flight holds.
// Reset returns the geometry to 640x480, the kernel to the 1/9 box filter and
// the position to the top left; line store contents are not cleared.
// ============================================================================
module rgba_convolution_3x3
    import rgbac_pkg::*;
#(
    parameter int MAX_WIDTH      = 4096,
    parameter int MAX_HEIGHT     = 4096,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Pixel input
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CHAN_W-1:0]     red_in,
    input  logic [CHAN_W-1:0]     green_in,
    input  logic [CHAN_W-1:0]     blue_in,
    input  logic [CHAN_W-1:0]     alpha_in,
    // Filtered output
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CHAN_W-1:0]     red_out,
    output logic [CHAN_W-1:0]     green_out,
    output logic [CHAN_W-1:0]     blue_out,
    output logic [CHAN_W-1:0]     alpha_out,
    output logic [POS_W-1:0]      out_row,
    output logic [POS_W-1:0]      out_col,
    output logic                  frame_done,
    // Configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Column and row indices and the width and height values they are compared against.
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = RW + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_CFG_W-1:0]  frame_width_reg;
    logic [DIM_CFG_W-1:0]  frame_height_reg;
    logic [CFG_DATA_W-1:0] coef_row_reg [TAPS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            for (int y = 0; y < TAPS; y++)
            begin
                coef_row_reg[y] <= COEF_ROW_RST;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_CFG_W-1:0];
                REG_COEF_TOP:     coef_row_reg[0]  <= cfg_data;
                REG_COEF_MID:     coef_row_reg[1]  <= cfg_data;
                REG_COEF_BOTTOM:  coef_row_reg[2]  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together.
    // ------------------------------------------------------------------
    logic adv;
    logic in_accept;

    assign adv       = !out_valid || !out_stall;
    assign in_stall  = !adv;
    assign in_accept = in_valid && adv;

    // ------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------
    logic [CW-1:0] col_reg, col_next, col_pre;
    logic [RW-1:0] row_reg, row_next, row_pre;
    logic [WW-1:0] w_eff, col_inc;
    logic [HW-1:0] h_eff, row_wide, row_inc;
    logic          emit;
    logic          done;

    always_comb
    begin
        // The active geometry is the register value clamped to 3..MAX.
        if (frame_width_reg < DIM_CFG_W'(3))
        begin
            w_eff = WW'(3);
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(frame_width_reg);
        end

        if (frame_height_reg < DIM_CFG_W'(3))
        begin
            h_eff = HW'(3);
        end
        else if (32'(frame_height_reg) > MAX_HEIGHT)
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(frame_height_reg);
        end

        // If the geometry shrank mid-frame, wrap the position first.
        col_pre  = col_reg;
        row_wide = {1'b0, row_reg};
        if ({1'b0, col_reg} >= w_eff)
        begin
            col_pre  = '0;
            row_wide = {1'b0, row_reg} + HW'(1);
        end
        if (row_wide >= h_eff)
        begin
            row_wide = '0;
        end
        row_pre = row_wide[RW-1:0];

        col_inc = {1'b0, col_pre} + WW'(1);
        row_inc = {1'b0, row_pre} + HW'(1);
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            row_next = row_pre;
        end

        emit = (row_pre >= RW'(2)) && (col_pre >= CW'(2));
        done = ({1'b0, row_pre} == h_eff - HW'(1)) &&
               ({1'b0, col_pre} == w_eff - WW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line stores are read at the current column.
    // ------------------------------------------------------------------
    logic          s1_valid_reg;
    logic          s1_emit_reg;
    meta_t         s1_meta_reg;
    pixel_t        s1_pix_reg;
    logic [CW-1:0] s1_addr_reg;
    pixel_t        upper_rd;
    pixel_t        middle_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_emit_reg      <= emit;
            s1_meta_reg.done <= done;
            s1_meta_reg.row  <= POS_W'(32'(row_pre) - 32'd1);
            s1_meta_reg.col  <= POS_W'(32'(col_pre) - 32'd1);
            s1_pix_reg       <= {alpha_in, blue_in, green_in, red_in};
            s1_addr_reg      <= col_pre;
        end
    end

    // The upper store takes what the middle store held; the middle store
    // takes the new pixel. Both are written as the window shifts.
    rgbac_ram #(
        .WIDTH (NUM_CH * CHAN_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .clk     (clk),
        .wr_en   (adv && s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (middle_rd),
        .rd_en   (adv),
        .rd_addr (col_pre),
        .rd_data (upper_rd)
    );

    rgbac_ram #(
        .WIDTH (NUM_CH * CHAN_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .clk     (clk),
        .wr_en   (adv && s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (adv),
        .rd_addr (col_pre),
        .rd_data (middle_rd)
    );

    // ------------------------------------------------------------------
    // Window: a chain of three column cells, the right one fed from the
    // line stores and the new pixel, each shifting into its left neighbor.
    // ------------------------------------------------------------------
    cell_ctl_t cell_ctl;
    column_t   cell_in  [TAPS];
    column_t   cell_out [TAPS];
    csum_vec_t cell_sum [TAPS];

    assign cell_ctl.load = adv && s1_valid_reg;
    assign cell_ctl.adv  = adv;

    for (genvar x = 0; x < TAPS; x++)
    begin : g_cell
        coef_col_t coef;

        for (genvar y = 0; y < TAPS; y++)
        begin : g_coef
            assign coef[y] = coef_row_reg[y][COEF_W*x +: COEF_W];
        end

        if (x == TAPS - 1)
        begin : g_feed
            assign cell_in[x] = {s1_pix_reg, middle_rd, upper_rd};
        end
        else
        begin : g_link
            assign cell_in[x] = cell_out[x+1];
        end

        rgbac_cell u_cell (
            .clk     (clk),
            .ctl     (cell_ctl),
            .col_in  (cell_in[x]),
            .coef    (coef),
            .col_out (cell_out[x]),
            .sum_out (cell_sum[x])
        );
    end

    // ------------------------------------------------------------------
    // Stages 2..4 carry the position alongside the cell arithmetic.
    // ------------------------------------------------------------------
    logic  s2_valid_reg, s3_valid_reg, s4_valid_reg;
    meta_t s2_meta_reg, s3_meta_reg, s4_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_meta_reg <= s1_meta_reg;
            s3_meta_reg <= s2_meta_reg;
            s4_meta_reg <= s3_meta_reg;
        end
    end

    // ------------------------------------------------------------------
    // Final sum, scale back by the fraction bits and saturate to 0..255.
    // A sum at or below zero gives zero.
    // ------------------------------------------------------------------
    logic signed [TSUM_W-1:0] tsum [NUM_CH];
    logic        [TSUM_W-1:0] tsum_q [NUM_CH];
    pixel_t                   res_pix;

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            tsum[ch] = TSUM_W'($signed(cell_sum[0][ch])) +
                       TSUM_W'($signed(cell_sum[1][ch])) +
                       TSUM_W'($signed(cell_sum[2][ch]));
            tsum_q[ch] = tsum[ch] >> COEF_FRAC_BITS;
            if (tsum[ch] <= 0)
            begin
                res_pix[ch] = '0;
            end
            else if (tsum_q[ch] > TSUM_W'(CHAN_MAX))
            begin
                res_pix[ch] = CHAN_MAX;
            end
            else
            begin
                res_pix[ch] = tsum_q[ch][CHAN_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic   out_valid_reg;
    pixel_t out_pix_reg;
    meta_t  out_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_pix_reg  <= res_pix;
            out_meta_reg <= s4_meta_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = out_pix_reg[0];
    assign green_out  = out_pix_reg[1];
    assign blue_out   = out_pix_reg[2];
    assign alpha_out  = out_pix_reg[3];
    assign out_row    = out_meta_reg.row;
    assign out_col    = out_meta_reg.col;
    assign frame_done = out_meta_reg.done;

endmodule

[hdl/rgbac_checker.sv]
// ============================================================================
// RGBA 3x3 convolution checker
// Port-level assertions on the filter's channels, bound to the top level.
// ============================================================================
module rgbac_checker
    import rgbac_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              cfg_ready,
    input logic [CHAN_W-1:0] red_out,
    input logic [CHAN_W-1:0] green_out,
    input logic [CHAN_W-1:0] blue_out,
    input logic [CHAN_W-1:0] alpha_out,
    input logic [POS_W-1:0]  out_row,
    input logic [POS_W-1:0]  out_col,
    input logic              frame_done
);

    // A stalled output word stays offered.
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its contents.
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(red_out) && $stable(green_out) &&
            $stable(blue_out) && $stable(alpha_out) && $stable(out_row) &&
            $stable(out_col) && $stable(frame_done))
        else $error("output word changed while stalled");

    // The pipeline moves as one unit, so a held output word stalls the input.
    a_stall_through: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while output is held");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind rgba_convolution_3x3 rgbac_checker u_rgbac_checker (.*);
